/* sv/mexp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants, types and helpers of the modular exponentiation unit.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS);
    localparam int ADDR_BITS = 3;
    localparam int REG_SEL   = 2;

    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    localparam logic [WORD_BITS-1:0] EXPONENT_RESET = WORD_BITS'(1);
    localparam logic [WORD_BITS-1:0] MODULUS_RESET  = WORD_BITS'(2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED,
        S_RED_END,
        S_CHECK,
        S_SQR,
        S_BIT,
        S_MUL,
        S_NEXT,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RED,
        OP_SETUP,
        OP_SQ_LOAD,
        OP_ML_LOAD,
        OP_MSTEP,
        OP_EDEC,
        OP_RES_ZERO,
        OP_RES_RED,
        OP_RES_ACC
    } t_dp_op;

    typedef struct packed {
        logic cnt_zero;
        logic eidx_zero;
        logic ebit;
        logic mod_zero;
        logic exp_small;
    } t_dp_status;

    function automatic logic [WORD_BITS-1:0] add_mod(
        input logic [WORD_BITS-1:0] x,
        input logic [WORD_BITS-1:0] y,
        input logic [WORD_BITS-1:0] m
    );
        logic [WORD_BITS:0] sum;
        logic [WORD_BITS:0] diff;
        sum  = {1'b0, x} + {1'b0, y};
        diff = sum - {1'b0, m};
        if (sum >= {1'b0, m}) begin
            add_mod = diff[WORD_BITS-1:0];
        end else begin
            add_mod = sum[WORD_BITS-1:0];
        end
    endfunction

endpackage

/* sv/mexp_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: input reduction, shift-and-add modular multiplier, operand and
// accumulator registers, exponent bit index.
// ----------------------------------------------------------------------------
module mexp_dp (
    input  logic                            i_clk,
    input  mexp_pkg::t_dp_op                i_op,
    input  logic [mexp_pkg::WORD_BITS-1:0]  i_value,
    input  logic [mexp_pkg::WORD_BITS-1:0]  i_exponent,
    input  logic [mexp_pkg::WORD_BITS-1:0]  i_modulus,
    output mexp_pkg::t_dp_status            o_sts,
    output logic [mexp_pkg::WORD_BITS-1:0]  o_result
);
    import mexp_pkg::*;

    logic [WORD_BITS-1:0] r_v;
    logic [WORD_BITS-1:0] r_r;
    logic [WORD_BITS-1:0] r_a;
    logic [WORD_BITS-1:0] r_b;
    logic [WORD_BITS-1:0] r_base;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_res;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [CNT_BITS-1:0]  r_eidx;

    logic [WORD_BITS:0]   red_sum;
    logic [WORD_BITS:0]   red_diff;
    logic [WORD_BITS-1:0] red_next;
    logic [WORD_BITS-1:0] dbl;
    logic [WORD_BITS-1:0] mul_next;

    always_comb begin
        red_sum  = {r_r, r_v[r_cnt]};
        red_diff = red_sum - {1'b0, i_modulus};
        red_next = (red_sum >= {1'b0, i_modulus}) ? red_diff[WORD_BITS-1:0]
                                                   : red_sum[WORD_BITS-1:0];
        dbl      = add_mod(r_r, r_r, i_modulus);
        mul_next = r_b[r_cnt] ? add_mod(dbl, r_a, i_modulus) : dbl;
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_v   <= i_value;
                r_r   <= '0;
                r_cnt <= CNT_BITS'(WORD_BITS - 1);
            end
            OP_RED: begin
                r_r   <= red_next;
                r_cnt <= r_cnt - 1'b1;
            end
            OP_SETUP: begin
                r_base <= r_r;
                r_acc  <= (i_modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
                r_eidx <= CNT_BITS'(WORD_BITS - 1);
            end
            OP_SQ_LOAD: begin
                r_a   <= r_acc;
                r_b   <= r_acc;
                r_r   <= '0;
                r_cnt <= CNT_BITS'(WORD_BITS - 1);
            end
            OP_ML_LOAD: begin
                r_a   <= r_acc;
                r_b   <= r_base;
                r_r   <= '0;
                r_cnt <= CNT_BITS'(WORD_BITS - 1);
            end
            OP_MSTEP: begin
                r_r   <= mul_next;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_acc <= mul_next;
                end
            end
            OP_EDEC:     r_eidx <= r_eidx - 1'b1;
            OP_RES_ZERO: r_res  <= '0;
            OP_RES_RED:  r_res  <= r_r;
            OP_RES_ACC:  r_res  <= r_acc;
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.cnt_zero  = (r_cnt == '0);
        o_sts.eidx_zero = (r_eidx == '0);
        o_sts.ebit      = i_exponent[r_eidx];
        o_sts.mod_zero  = (i_modulus == '0);
        o_sts.exp_small = (i_exponent[WORD_BITS-1:1] == '0);
    end

    assign o_result = r_res;

endmodule

/* sv/mexp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_ctrl
// Controller: sequences reduction, square-and-multiply and result hand-off.
// ----------------------------------------------------------------------------
module mexp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_out_free,
    output logic                  o_res_load,
    input  mexp_pkg::t_dp_status  i_sts,
    output mexp_pkg::t_dp_op      o_op
);
    import mexp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_started;
    logic   n_started;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_started  = r_started;
        o_op       = OP_NONE;
        o_in_stall = 1'b1;
        o_res_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_RED;
                end
            end
            S_RED: begin
                o_op = OP_RED;
                if (i_sts.cnt_zero) begin
                    n_state = S_RED_END;
                end
            end
            S_RED_END: begin
                n_state = S_DONE;
                if (i_sts.mod_zero) begin
                    o_op = OP_RES_ZERO;
                end else if (i_sts.exp_small) begin
                    o_op = OP_RES_RED;
                end else begin
                    o_op      = OP_SETUP;
                    n_started = 1'b0;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_started) begin
                    o_op    = OP_SQ_LOAD;
                    n_state = S_SQR;
                end else begin
                    n_state = S_BIT;
                end
            end
            S_SQR: begin
                o_op = OP_MSTEP;
                if (i_sts.cnt_zero) begin
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                if (i_sts.ebit) begin
                    o_op      = OP_ML_LOAD;
                    n_started = 1'b1;
                    n_state   = S_MUL;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_MUL: begin
                o_op = OP_MSTEP;
                if (i_sts.cnt_zero) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_sts.eidx_zero) begin
                    o_op    = OP_RES_ACC;
                    n_state = S_DONE;
                end else begin
                    o_op    = OP_EDEC;
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_sqr_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SQR |-> r_started)
        else $error("squaring before the first set exponent bit");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && !i_out_free |=> r_state == S_DONE)
        else $error("result dropped while output busy");

    a_red_end_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RED_END |-> $past(r_state) == S_RED)
        else $error("reduction end reached out of sequence");

    a_mul_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL && !i_sts.cnt_zero |=> r_state == S_MUL)
        else $error("multiply left before its last step");

endmodule

/* sv/modular_exponentiation_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// Raises each input item to the configured exponent modulo the configured
// modulus (RSA encryption or decryption of one word per item).
// ----------------------------------------------------------------------------
//  channel  | handshake                       | payload
//  ---------+---------------------------------+----------------------------
//  input    | i_in_valid  / o_in_stall        | i_value_in  [31:0]
//  output   | o_out_valid / i_out_stall       | o_value_out [31:0]
//  config   | psel penable pwrite pready      | paddr pwdata prdata
//
//  Per item: input reduction, then for each of the 32 exponent bit positions,
//  a square once a set bit is seen and a multiply for each set bit, both on
//  the 32-step shift-and-add modular multiplier.
//  Exponent 0 or 1, or modulus 0: input reduction only.
//  Reset is synchronous, active low; exponent resets to 1, modulus to 2.
//  A stalled result sits in the output register; the next item is taken.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [mexp_pkg::WORD_BITS-1:0]      i_value_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mexp_pkg::WORD_BITS-1:0]      o_value_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mexp_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [mexp_pkg::WORD_BITS-1:0]      pwdata,
    output logic [mexp_pkg::WORD_BITS-1:0]      prdata,
    output logic                                pready
);
    import mexp_pkg::*;

    logic [WORD_BITS-1:0] r_exponent;
    logic [WORD_BITS-1:0] r_modulus;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out;

    logic                 cfg_write;
    logic                 out_free;
    logic                 res_load;
    t_dp_op               op;
    t_dp_status           sts;
    logic [WORD_BITS-1:0] result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= EXPONENT_RESET;
            r_modulus  <= MODULUS_RESET;
        end else if (cfg_write) begin
            case (paddr[REG_SEL])
                REG_EXPONENT: r_exponent <= pwdata;
                REG_MODULUS:  r_modulus  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_SEL])
            REG_EXPONENT: prdata = r_exponent;
            REG_MODULUS:  prdata = r_modulus;
            default:      prdata = '0;
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value_out = r_out;

    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_free (out_free),
        .o_res_load (res_load),
        .i_sts      (sts),
        .o_op       (op)
    );

    mexp_dp u_dp (
        .i_clk      (i_clk),
        .i_op       (op),
        .i_value    (i_value_in),
        .i_exponent (r_exponent),
        .i_modulus  (r_modulus),
        .o_sts      (sts),
        .o_result   (result)
    );

endmodule
